// File: rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit package
// Operation codes, field constants, the carry-less multiply and the
// constant inverse table shared by the unit's files.
// ----------------------------------------------------------------------------
package gfau_pkg;

	localparam int unsigned ELEM_W = 8;
	localparam int unsigned NUM_ELEMS = 1 << ELEM_W;

	// x^8 + x^4 + x^3 + x + 1
	localparam logic [ELEM_W:0] GF_POLY = 9'h11b;
	localparam logic [ELEM_W-1:0] GF_TOP = 8'h80;
	localparam logic [ELEM_W-1:0] GF_ONE = 8'h01;

	typedef logic [ELEM_W-1:0] elem_t;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_INV = 2'd3
	} action_t;

	typedef struct packed {
		elem_t result;
		logic  zero_inverse;
	} result_t;

	typedef elem_t inv_table_t [NUM_ELEMS];

	// Shift-and-add product; reduce whenever the multiplicand leaves bit 7.
	function automatic elem_t gf_mul(input elem_t a, input elem_t b);
		elem_t prod;
		elem_t sh;
		prod = '0;
		sh = a;
		for (int i = 0; i < ELEM_W; i++) begin
			if (b[i]) begin
				prod = prod ^ sh;
			end
			if ((sh & GF_TOP) != '0) begin
				sh = (sh << 1) ^ GF_POLY[ELEM_W-1:0];
			end else begin
				sh = sh << 1;
			end
		end
		return prod;
	endfunction

	// a^254 by square-and-multiply; only evaluated at elaboration.
	function automatic elem_t gf_pow254(input elem_t a);
		elem_t acc;
		elem_t sq;
		logic [ELEM_W-1:0] e;
		acc = GF_ONE;
		sq = a;
		e = 8'd254;
		for (int i = 0; i < ELEM_W; i++) begin
			if (e[i]) begin
				acc = gf_mul(acc, sq);
			end
			sq = gf_mul(sq, sq);
		end
		return acc;
	endfunction

	function automatic inv_table_t build_inv_table();
		inv_table_t tab;
		for (int i = 0; i < NUM_ELEMS; i++) begin
			tab[i] = gf_pow254(elem_t'(i));
		end
		return tab;
	endfunction

	localparam inv_table_t GF_INV_TABLE = build_inv_table();

endpackage

// File: rtl/gfau_in_if.sv
// ----------------------------------------------------------------------------
// GF(2^8) unit input channel
// Valid/ready channel carrying one operation and two field elements.
// ----------------------------------------------------------------------------
interface gfau_in_if;
	logic             valid;
	logic             ready;
	gfau_pkg::action_t action;
	logic [7:0]       operand_a;
	logic [7:0]       operand_b;

	modport source (output valid, output action, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input action, input operand_a, input operand_b,
		output ready);
endinterface

// File: rtl/gfau_out_if.sv
// ----------------------------------------------------------------------------
// GF(2^8) unit output channel
// Valid/ready channel carrying one result element and the zero-inverse flag.
// ----------------------------------------------------------------------------
interface gfau_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       zero_inverse;

	modport source (output valid, output result, output zero_inverse, input ready);
	modport sink (input valid, input result, input zero_inverse, output ready);
endinterface

// File: rtl/gfau_alu.sv
// ----------------------------------------------------------------------------
// GF(2^8) operation logic
// Combinational add/subtract, multiply and inverse for one registered item.
// ----------------------------------------------------------------------------
module gfau_alu (
	input  gfau_pkg::action_t action,
	input  gfau_pkg::elem_t   operand_a,
	input  gfau_pkg::elem_t   operand_b,
	output gfau_pkg::result_t res
);
	import gfau_pkg::*;

	elem_t prod;
	elem_t inv;

	assign prod = gf_mul(operand_a, operand_b);
	assign inv  = GF_INV_TABLE[operand_a];

	always_comb begin
		res = '0;
		case (action)
			ACT_ADD, ACT_SUB: begin
				res.result = operand_a ^ operand_b;
			end
			ACT_MUL: begin
				res.result = prod;
			end
			ACT_INV: begin
				// zero has no inverse: flag it and return zero
				if (operand_a == '0) begin
					res.zero_inverse = 1'b1;
				end else begin
					res.result = inv;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end
endmodule

// File: rtl/gf256_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit
// Two-register pipeline around add, multiply and inverse over poly 0x11b.
// ----------------------------------------------------------------------------
// Each transfer on in_ch carries an operation (add, subtract, multiply or
// inverse of operand_a) and two bytes; exactly one transfer on out_ch follows
// it, in order. The unit takes one item per cycle while out_ch does not hold
// it back. The item is captured in the input register, the field logic
// (an eight-step carry-less multiply and a 256-entry constant inverse table)
// works on it combinationally, the answer is loaded into the result register
// and sits there until taken, and output valid rises once it is loaded.
// Add and subtract are both XOR. The inverse of zero returns 0 with
// zero_inverse set; the flag is 0 for every other item.
// Back-pressure on out_ch stalls the result register and then the input
// register, so at most two items are held inside.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit (
	input logic        clk,
	input logic        arst_n,
	gfau_in_if.sink    in_ch,
	gfau_out_if.source out_ch
);
	import gfau_pkg::*;

	// input register
	logic    valid_s1;
	action_t action_s1;
	elem_t   a_s1;
	elem_t   b_s1;

	// result register
	logic    valid_s2;
	result_t res_s2;

	result_t alu_res;
	logic    adv_s1;
	logic    adv_s2;
	logic    take_in;

	// Stage 2 can load when it is empty or its item leaves this cycle.
	assign adv_s2  = !valid_s2 || out_ch.ready;
	// Stage 1 can load when it is empty or its item moves on.
	assign adv_s1  = !valid_s1 || adv_s2;
	assign take_in = in_ch.valid && adv_s1;

	assign in_ch.ready = adv_s1;

	// Hold the input item while the result register is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= in_ch.action;
			a_s1      <= in_ch.operand_a;
			b_s1      <= in_ch.operand_b;
		end
	end

	gfau_alu u_alu (
		.action    (action_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.res       (alu_res)
	);

	// Advance the computed answer into the result register; drop it on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= alu_res;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.result       = res_s2.result;
	assign out_ch.zero_inverse = res_s2.zero_inverse;

	// A flagged inverse always carries a zero result.
	a_zero_inv_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.zero_inverse |-> res_s2.result == '0)
		else $error("zero_inverse set with nonzero result");

	// An accepted item lands in the input register.
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> valid_s1)
		else $error("accepted item lost before input register");

	// An item leaving the input register lands in the result register.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("item lost between input and result register");

	// Input back-pressure only when both registers are full.
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && valid_s2 && !out_ch.ready)
		else $error("input stalled while pipeline has room");
endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit testbench
// Drives add, subtract, multiply and inverse items through the valid/ready
// channels with random idle bursts on both sides and a long output hold-off.
// Every transfer out of the unit is checked against a predictor that rebuilds
// the field arithmetic from the polynomial and finds inverses by search.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gfau_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD_AT = 400;
	localparam int unsigned LONG_HOLD_CYCLES = 60;
	localparam int unsigned TAIL_ITEMS = 150;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct {
		action_t op;
		elem_t   a;
		elem_t   b;
		bit      drain_first;
	} field_op_t;

	logic clk;
	logic arst_n;

	gfau_in_if in_ch();
	gfau_out_if out_ch();

	gf256_arithmetic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Items waiting to be offered, and answers waiting to come out, in order.
	field_op_t pending_ops[$];
	result_t   expected_answers[$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned answers_seen = 0;
	int unsigned zero_flags_seen = 0;
	int unsigned op_count[4] = '{0, 0, 0, 0};

	// Driver state
	int unsigned gap_left = 0;
	bit          send_bursty = 1'b1;
	logic        valid_next;
	field_op_t   head_op;

	// Monitor state
	int unsigned stall_left = 0;
	bit          recv_bursty = 1'b1;
	bit          long_hold_done = 1'b0;
	logic        ready_next;
	result_t     want;

	// ------------------------------------------------------------------------
	// Predictor: shift-and-add product over x^8 + x^4 + x^3 + x + 1
	// ------------------------------------------------------------------------
	function automatic elem_t field_product(elem_t x, elem_t y);
		elem_t acc;
		elem_t m;
		acc = '0;
		m = x;
		for (int k = 0; k < ELEM_W; k++) begin
			if (y[k]) begin
				acc = acc ^ m;
			end
			// Shift the multiplicand; fold bit 8 back in through the polynomial.
			m = {m[ELEM_W-2:0], 1'b0} ^ (m[ELEM_W-1] ? GF_POLY[ELEM_W-1:0] : elem_t'(0));
		end
		return acc;
	endfunction

	function automatic result_t predict_answer(action_t op, elem_t a, elem_t b);
		result_t r;
		r.result = '0;
		r.zero_inverse = 1'b0;
		case (op)
			ACT_ADD, ACT_SUB: begin
				r.result = a ^ b;
			end
			ACT_MUL: begin
				r.result = field_product(a, b);
			end
			ACT_INV: begin
				// Zero has no inverse: answer 0 and raise the flag.
				if (a == '0) begin
					r.zero_inverse = 1'b1;
				end else begin
					// Search the group for the element whose product with a is one.
					for (int c = 1; c < NUM_ELEMS; c++) begin
						if (field_product(a, elem_t'(c)) == GF_ONE) begin
							r.result = elem_t'(c);
						end
					end
				end
			end
			default: begin
				r.result = '0;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_op(action_t op, elem_t a, elem_t b, bit drain = 1'b0);
		field_op_t item;
		item.op = op;
		item.a = a;
		item.b = b;
		item.drain_first = drain;
		pending_ops.push_back(item);
	endtask

	// Bias operands toward zero, all ones and single bits; rest uniform.
	function automatic elem_t pick_operand();
		elem_t v;
		case ($urandom_range(0, 15))
			0: v = 8'h00;
			1: v = 8'hff;
			2: v = elem_t'(1) << $urandom_range(0, ELEM_W - 1);
			default: v = elem_t'($urandom_range(0, NUM_ELEMS - 1));
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Clock and reset; hold every input at a known value from time zero
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_ADD;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		out_ch.ready = 1'b0;
		fork
			forever #10 clk = ~clk;
			begin
				repeat (4) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d answers still owed",
				$realtime, cycle_count, expected_answers.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver: offer queued items, push the predicted answer at each transfer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= ACT_ADD;
			in_ch.operand_a <= '0;
			in_ch.operand_b <= '0;
			gap_left = 0;
		end else begin
			valid_next = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				expected_answers.push_back(predict_answer(in_ch.action, in_ch.operand_a,
					in_ch.operand_b));
				op_count[in_ch.action]++;
				valid_next = 1'b0;
			end
			// Switch now and then between bursty and steady sending.
			if ($urandom_range(0, 79) == 0) begin
				send_bursty = ~send_bursty;
			end
			if (!valid_next) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0 &&
					!(pending_ops[0].drain_first && expected_answers.size() != 0)) begin
					head_op = pending_ops.pop_front();
					in_ch.action <= head_op.op;
					in_ch.operand_a <= head_op.a;
					in_ch.operand_b <= head_op.b;
					valid_next = 1'b1;
					// Leave a gap after this item now and then, never in the tail.
					if (send_bursty && pending_ops.size() >= TAIL_ITEMS &&
						$urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(1, 13);
					end
				end
			end
			in_ch.valid <= valid_next;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each answer transfer, decide the ready for the next cycle
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				answers_seen++;
				if (out_ch.zero_inverse) begin
					zero_flags_seen++;
				end
				if (expected_answers.size() == 0) begin
					error_count++;
					$display("%0t: answer with nothing owed: result %02h zero_inverse %0b",
						$realtime, out_ch.result, out_ch.zero_inverse);
				end else begin
					want = expected_answers.pop_front();
					if (out_ch.result !== want.result) begin
						error_count++;
						$display("%0t: result mismatch: expected %02h actual %02h",
							$realtime, want.result, out_ch.result);
					end
					if (out_ch.zero_inverse !== want.zero_inverse) begin
						error_count++;
						$display("%0t: zero_inverse mismatch: expected %0b actual %0b",
							$realtime, want.zero_inverse, out_ch.zero_inverse);
					end
				end
			end
			if ($urandom_range(0, 79) == 0) begin
				recv_bursty = ~recv_bursty;
			end
			// Hold off once for a long stretch so the unit fills and stalls its input.
			if (stall_left != 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else if (!long_hold_done && answers_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES - 1;
				ready_next = 1'b0;
			end else if (recv_bursty && pending_ops.size() >= TAIL_ITEMS &&
				$urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			out_ch.ready <= ready_next;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		// Directed: field extremes, every operation, reduction and inverse corners.
		queue_op(ACT_ADD, 8'h00, 8'h00);
		queue_op(ACT_ADD, 8'hff, 8'hff);
		queue_op(ACT_ADD, 8'ha5, 8'h5a);
		queue_op(ACT_SUB, 8'h80, 8'h01);
		queue_op(ACT_SUB, 8'hff, 8'h00);
		queue_op(ACT_SUB, 8'h00, 8'hff);
		queue_op(ACT_MUL, 8'h00, 8'hff);
		queue_op(ACT_MUL, 8'hff, 8'h00);
		queue_op(ACT_MUL, 8'hff, 8'hff);
		queue_op(ACT_MUL, 8'h80, 8'h02);
		queue_op(ACT_MUL, 8'h02, 8'h80);
		queue_op(ACT_MUL, 8'h01, 8'hb7);
		queue_op(ACT_MUL, 8'h53, 8'hca);
		queue_op(ACT_MUL, 8'h80, 8'h80);
		// Inverse of zero, with and without a nonzero second operand, then nonzero inverses.
		queue_op(ACT_INV, 8'h00, 8'h00);
		queue_op(ACT_INV, 8'h00, 8'hff);
		queue_op(ACT_INV, 8'h01, 8'h00);
		queue_op(ACT_INV, 8'hff, 8'h00);
		queue_op(ACT_INV, 8'h80, 8'h7f);
		queue_op(ACT_INV, 8'h53, 8'hff);
		queue_op(ACT_INV, 8'h02, 8'h55);
		// Random part; at a few points hold the sender until everything is out.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			queue_op(action_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				n == 0 || n == 600 || n == 1200);
		end

		// Wait for the queue to empty and every answer to come back, then settle.
		do begin
			@(posedge clk);
		end while (pending_ops.size() != 0 || in_ch.valid || expected_answers.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d transfers: %0d add, %0d subtract, %0d multiply, %0d inverse",
			op_count[ACT_ADD] + op_count[ACT_SUB] + op_count[ACT_MUL] + op_count[ACT_INV],
			op_count[ACT_ADD], op_count[ACT_SUB], op_count[ACT_MUL], op_count[ACT_INV]);
		$display("Checked %0d answers (%0d zero-inverse flags) in %0d cycles, %0d errors",
			answers_seen, zero_flags_seen, cycle_count, error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
